FILE: rtl/core/sadt_pkg.sv
// Shared constants and types for the slot arg-max text decoder.
// Used by the register block, the front end, the back end and the top level.
// Depends on nothing.
`default_nettype none

package sadt_pkg;

  localparam int MAX_VOCAB = 128;
  localparam int MAX_SLOTS = 32;
  localparam int PROB_BITS = 16;

  localparam int VOCAB_W = 8;
  localparam int INDEX_W = 7;
  localparam int THR_W = 16;
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] REG_VOCAB_SIZE = 2'd0;
  localparam logic [1:0] REG_PAD_INDEX = 2'd1;
  localparam logic [1:0] REG_ACCEPT_THRESHOLD = 2'd2;

  localparam logic [VOCAB_W-1:0] VOCAB_RESET = 8'd36;
  localparam logic [INDEX_W-1:0] PAD_RESET = 7'd0;
  localparam logic [THR_W-1:0] THR_RESET = 16'd32768;

  typedef struct packed {
    logic [VOCAB_W-1:0] vocab_size;
    logic [INDEX_W-1:0] pad_index;
    logic [THR_W-1:0] accept_threshold;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/sadt_regs.sv
// Configuration registers behind an APB-style port.
// Depends on sadt_pkg for register codes, reset values and the cfg_t bundle.
`default_nettype none

module sadt_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sadt_pkg::APB_AW-1:0]  paddr,
  input  wire logic [sadt_pkg::APB_DW-1:0]  pwdata,
  output logic      [sadt_pkg::APB_DW-1:0]  prdata,
  output logic                              pready,
  output sadt_pkg::cfg_t                    cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx = paddr[3:2];
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vocab_size <= sadt_pkg::VOCAB_RESET;
      cfg.pad_index <= sadt_pkg::PAD_RESET;
      cfg.accept_threshold <= sadt_pkg::THR_RESET;
    end else if (wr) begin
      case (idx)
        sadt_pkg::REG_VOCAB_SIZE: cfg.vocab_size <= pwdata[sadt_pkg::VOCAB_W-1:0];
        sadt_pkg::REG_PAD_INDEX: cfg.pad_index <= pwdata[sadt_pkg::INDEX_W-1:0];
        sadt_pkg::REG_ACCEPT_THRESHOLD:
          cfg.accept_threshold <= pwdata[sadt_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      sadt_pkg::REG_VOCAB_SIZE: prdata[sadt_pkg::VOCAB_W-1:0] = cfg.vocab_size;
      sadt_pkg::REG_PAD_INDEX: prdata[sadt_pkg::INDEX_W-1:0] = cfg.pad_index;
      sadt_pkg::REG_ACCEPT_THRESHOLD:
        prdata[sadt_pkg::THR_W-1:0] = cfg.accept_threshold;
      default: prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/sadt_front.sv
// Front end: takes probability beats, tracks the slot maximum and the tensor totals,
// and pushes symbol and summary jobs into the queue. Depends on sadt_pkg.
`default_nettype none

module sadt_front #(
  parameter int MAX_SLOTS = sadt_pkg::MAX_SLOTS,
  parameter int CNT_W = $clog2(MAX_SLOTS + 1),
  parameter int SUM_W = sadt_pkg::PROB_BITS + CNT_W,
  parameter int JOB_W = 1 + sadt_pkg::INDEX_W + 3 + CNT_W + SUM_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire sadt_pkg::cfg_t                  cfg,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [sadt_pkg::PROB_BITS-1:0]  s_tdata,
  input  wire logic                            s_tlast,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output logic      [JOB_W-1:0]                q_job
);

  localparam int PW = sadt_pkg::INDEX_W;
  localparam int VW = sadt_pkg::VOCAB_W;

  logic [PW-1:0]                  pos;
  logic [sadt_pkg::PROB_BITS-1:0] best_val;
  logic [PW-1:0]                  best_idx;
  logic [CNT_W-1:0]               cnt;
  logic [SUM_W-1:0]               sum;
  logic                           any_sym;
  logic                           ovf;

  logic                           beat;
  logic                           take;
  logic [sadt_pkg::PROB_BITS-1:0] val_next;
  logic [PW-1:0]                  idx_next;
  logic [VW-1:0]                  veff;
  logic [VW-1:0]                  pos_inc;
  logic                           close;
  logic                           slot_ok;
  logic                           emit_sym;
  logic [CNT_W-1:0]               cnt_next;
  logic [SUM_W-1:0]               sum_next;
  logic                           any_next;
  logic                           ovf_next;
  logic                           err;

  assign s_tready = !q_full;
  assign beat = s_tvalid && s_tready;

  always_comb begin
    if (cfg.vocab_size == '0) begin
      veff = VW'(1);
    end else if (cfg.vocab_size > VW'(sadt_pkg::MAX_VOCAB)) begin
      veff = VW'(sadt_pkg::MAX_VOCAB);
    end else begin
      veff = cfg.vocab_size;
    end
    take = (pos == '0) || (s_tdata > best_val);
    val_next = take ? s_tdata : best_val;
    idx_next = take ? pos : best_idx;
    pos_inc = VW'(pos) + VW'(1);
    close = pos_inc >= veff;
    slot_ok = close && (cnt < CNT_W'(MAX_SLOTS));
    ovf_next = ovf || (close && !slot_ok);
    cnt_next = cnt + CNT_W'(slot_ok);
    sum_next = sum + (slot_ok ? SUM_W'(val_next) : '0);
    emit_sym = slot_ok && (idx_next != cfg.pad_index);
    any_next = any_sym || emit_sym;
    err = ovf_next || !close;
    q_push = beat && (emit_sym || s_tlast);
    q_job = {emit_sym, idx_next, s_tlast, any_next, err, cnt_next, sum_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      best_val <= '0;
      best_idx <= '0;
      cnt <= '0;
      sum <= '0;
      any_sym <= 1'b0;
      ovf <= 1'b0;
    end else if (beat) begin
      if (s_tlast) begin
        pos <= '0;
        best_val <= '0;
        best_idx <= '0;
        cnt <= '0;
        sum <= '0;
        any_sym <= 1'b0;
        ovf <= 1'b0;
      end else begin
        pos <= close ? '0 : pos_inc[PW-1:0];
        best_val <= val_next;
        best_idx <= idx_next;
        cnt <= cnt_next;
        sum <= sum_next;
        any_sym <= any_next;
        ovf <= ovf_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sadt_queue.sv
// Small job queue between the front end and the back end.
// Depends on sadt_pkg for its default depth.
`default_nettype none

module sadt_queue #(
  parameter int W = 8,
  parameter int DEPTH = sadt_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  input  wire logic         pop,
  output logic      [W-1:0] dout,
  output logic              full,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full = count == CW'(DEPTH);
  assign empty = count == '0;
  assign dout = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sadt_back.sv
// Back end: drains jobs, sends symbol beats, divides the confidence sum by the
// slot count one quotient bit a cycle and sends the summary. Depends on sadt_pkg.
`default_nettype none

module sadt_back #(
  parameter int MAX_SLOTS = sadt_pkg::MAX_SLOTS,
  parameter int CNT_W = $clog2(MAX_SLOTS + 1),
  parameter int SUM_W = sadt_pkg::PROB_BITS + CNT_W,
  parameter int JOB_W = 1 + sadt_pkg::INDEX_W + 3 + CNT_W + SUM_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sadt_pkg::cfg_t     cfg,
  input  wire logic               q_empty,
  input  wire logic [JOB_W-1:0]   q_job,
  output logic                    q_pop,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic      [31:0]        m_tdata,
  output logic                    m_tlast,
  output logic                    m_tuser
);

  localparam int PB = sadt_pkg::PROB_BITS;
  localparam int IW = sadt_pkg::INDEX_W;
  localparam int DW = $clog2(SUM_W + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_SUM = 2'd2;

  logic [1:0]       state;
  logic [DW-1:0]    dcnt;
  logic [SUM_W-1:0] quo;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] divisor;
  logic             any_sym;
  logic             err;

  logic             j_sym;
  logic [IW-1:0]    j_idx;
  logic             j_sum;
  logic             j_any;
  logic             j_err;
  logic [CNT_W-1:0] j_cnt;
  logic [SUM_W-1:0] j_total;

  logic             out_free;
  logic [CNT_W:0]   rem_sh;
  logic             ge;
  logic [CNT_W:0]   diff;
  logic [PB-1:0]    mean;
  logic             acc;

  assign {j_sym, j_idx, j_sum, j_any, j_err, j_cnt, j_total} = q_job;
  assign out_free = !m_tvalid || m_tready;
  assign q_pop = (state == ST_IDLE) && !q_empty && out_free;

  always_comb begin
    rem_sh = {rem, quo[SUM_W-1]};
    ge = rem_sh >= {1'b0, divisor};
    diff = rem_sh - {1'b0, divisor};
    mean = (divisor == '0) ? '0 : quo[PB-1:0];
    acc = any_sym && !err && (mean >= cfg.accept_threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if ((q_pop && j_sym) || ((state == ST_SUM) && out_free)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop && j_sum) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dcnt == DW'(1)) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_pop) begin
          if (j_sym) begin
            m_tdata <= {25'd0, j_idx};
            m_tlast <= 1'b0;
            m_tuser <= 1'b1;
          end
          quo <= j_total;
          rem <= '0;
          divisor <= j_cnt;
          any_sym <= j_any;
          err <= j_err;
          dcnt <= DW'(SUM_W);
        end
      end
      ST_DIV: begin
        quo <= {quo[SUM_W-2:0], ge};
        rem <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        dcnt <= dcnt - DW'(1);
      end
      ST_SUM: begin
        if (out_free) begin
          m_tdata <= {7'd0, err, acc, mean, {IW{1'b0}}};
          m_tlast <= 1'b1;
          m_tuser <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/slot_argmax_text_decoder_unit.sv
// Top level of the greedy arg-max slot decoder: registers, front end, job queue, back end.
// Depends on sadt_pkg, sadt_regs, sadt_front, sadt_queue and sadt_back.
//
//   Channel  Direction  Beat carries
//   s_*      in         tdata[15:0] prob, tlast final_element
//   m_*      out        tuser is_symbol, tdata symbol/mean/accepted/size_error, tlast last
//   APB      in/out     vocab_size at 0x0, pad_index at 0x4, accept_threshold at 0x8
//
// The front end takes one probability beat per cycle while the four-entry job queue has room.
// A symbol beat is registered in the cycle after its job is taken from the queue; a summary
// is computed by the bit-serial restoring divider and is then sent from the summary state.
// Reset clears the tensor state and loads the register defaults. Either side may stall;
// a full queue holds s_tready low.
`default_nettype none

module slot_argmax_text_decoder_unit #(
  parameter int MAX_SLOTS = sadt_pkg::MAX_SLOTS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sadt_pkg::APB_AW-1:0]  paddr,
  input  wire logic [sadt_pkg::APB_DW-1:0]  pwdata,
  output logic      [sadt_pkg::APB_DW-1:0]  prdata,
  output logic                              pready,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [15:0]                  s_tdata,  // [15:0] prob
  input  wire logic                         s_tlast,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // [6:0] symbol_index, [22:7] mean_confidence, [23] accepted, [24] size_error
  output logic      [31:0]                  m_tdata,
  output logic                              m_tlast,
  output logic                              m_tuser   // [0] is_symbol
);

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int SUM_W = sadt_pkg::PROB_BITS + CNT_W;
  localparam int JOB_W = 1 + sadt_pkg::INDEX_W + 3 + CNT_W + SUM_W;

  sadt_pkg::cfg_t   cfg;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [JOB_W-1:0] q_din;
  logic [JOB_W-1:0] q_dout;

  sadt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sadt_front #(
    .MAX_SLOTS (MAX_SLOTS),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W),
    .JOB_W     (JOB_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_din)
  );

  sadt_queue #(
    .W     (JOB_W),
    .DEPTH (sadt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  sadt_back #(
    .MAX_SLOTS (MAX_SLOTS),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W),
    .JOB_W     (JOB_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_job    (q_dout),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

FILE: sim/slot_argmax_text_decoder_unit_test.sv
// Self-checking testbench for the slot arg-max text decoder, via its stream and APB ports.
// A directed table, then random tensors, are compared beat by beat against an in-bench decoder.
// Depends on sadt_pkg and slot_argmax_text_decoder_unit.
`default_nettype none

module slot_argmax_text_decoder_unit_test;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic [3:0] ADDR_VOCAB = {sadt_pkg::REG_VOCAB_SIZE, 2'b00};
  localparam logic [3:0] ADDR_PAD = {sadt_pkg::REG_PAD_INDEX, 2'b00};
  localparam logic [3:0] ADDR_THR = {sadt_pkg::REG_ACCEPT_THRESHOLD, 2'b00};
  localparam logic [3:0] ADDR_SPARE = {REG_SPARE, 2'b00};
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 460;

  typedef struct packed {
    logic                         is_symbol;
    logic [sadt_pkg::INDEX_W-1:0] symbol_index;
    logic [15:0]                  mean_confidence;
    logic                         accepted;
    logic                         size_error;
    logic                         last_result;
  } decode_t;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [3:0]  addr;
    logic [31:0] value;
    logic        fin;
    logic        typed;
    logic [15:0] want_mean;
    logic        want_acc;
    logic        want_err;
  } dir_row_t;

  localparam int DIR_ROWS = 35;
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_BEAT,  ADDR_VOCAB, 32'h0000_FFFF, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1},
    '{ROW_WRITE, ADDR_VOCAB, 32'd0,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_WRITE, ADDR_PAD,   32'd127,       1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_WRITE, ADDR_THR,   32'd0,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'h0000_0000, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0},
    '{ROW_WRITE, ADDR_SPARE, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'h0000_FFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'h0000_8000, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_WRITE, ADDR_VOCAB, 32'd4,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_WRITE, ADDR_PAD,   32'd2,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_WRITE, ADDR_THR,   32'hFFFF,      1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd5,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd9,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd9,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd1,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd7,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd7,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd7,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd7,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd0,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd0,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd3,         1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd0,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd0,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'h0000_FFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd0,         1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b0},
    '{ROW_WRITE, ADDR_VOCAB, 32'd8,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd100,       1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd300,       1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd200,       1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_WRITE, ADDR_VOCAB, 32'd2,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd50,        1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd9,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_WRITE, ADDR_PAD,   32'd1,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_BEAT,  ADDR_VOCAB, 32'd3,         1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}
  };

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [sadt_pkg::APB_AW-1:0] paddr;
  logic [sadt_pkg::APB_DW-1:0] pwdata;
  logic [sadt_pkg::APB_DW-1:0] prdata;
  logic                        pready;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [15:0]                 s_tdata;   // [15:0] prob
  logic                        s_tlast;
  logic                        m_tvalid;
  logic                        m_tready;
  logic [31:0]                 m_tdata;   // [6:0] symbol_index, [22:7] mean_confidence,
                                          // [23] accepted, [24] size_error
  logic                        m_tlast;
  logic                        m_tuser;   // [0] is_symbol

  slot_argmax_text_decoder_unit DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  sadt_pkg::cfg_t  shadow_cfg;
  int unsigned     elem_pos;
  logic [15:0]     best_value;
  logic [6:0]      best_index;
  int unsigned     slot_cnt;
  int unsigned     conf_sum;
  logic            any_symbol;
  logic            overflow;
  decode_t         pending_decodes[$];

  int              mismatches = 0;
  int              quiet_cycles = 0;
  int              items_sent = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  bit              hold_request = 0;
  int              hold_left = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int unsigned effective_vocab(input logic [7:0] raw);
    if (raw == 8'd0) return 1;
    if (raw > sadt_pkg::MAX_VOCAB) return sadt_pkg::MAX_VOCAB;
    return 32'(raw);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %0h, want %0h", what, got, want);
  endtask

  task automatic clear_tensor();
    elem_pos = 0;
    best_value = '0;
    best_index = '0;
    slot_cnt = 0;
    conf_sum = 0;
    any_symbol = 1'b0;
    overflow = 1'b0;
  endtask

  task automatic apply_write(input logic [3:0] addr, input logic [31:0] data);
    case (addr[3:2])
      sadt_pkg::REG_VOCAB_SIZE: begin
        shadow_cfg.vocab_size = data[sadt_pkg::VOCAB_W-1:0];
      end
      sadt_pkg::REG_PAD_INDEX: begin
        shadow_cfg.pad_index = data[sadt_pkg::INDEX_W-1:0];
      end
      sadt_pkg::REG_ACCEPT_THRESHOLD: begin
        shadow_cfg.accept_threshold = data[sadt_pkg::THR_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic decode_element(input logic [15:0] prob, input logic fin);
    int unsigned vocab;
    decode_t     r;
    logic        err;
    logic [15:0] mean;
    vocab = effective_vocab(shadow_cfg.vocab_size);
    if (elem_pos == 0 || prob > best_value) begin
      best_value = prob;
      best_index = elem_pos[6:0];
    end
    elem_pos++;
    if (elem_pos >= vocab) begin
      elem_pos = 0;
      if (slot_cnt >= sadt_pkg::MAX_SLOTS) begin
        overflow = 1'b1;
      end else begin
        slot_cnt++;
        conf_sum += best_value;
        if (best_index != shadow_cfg.pad_index) begin
          any_symbol = 1'b1;
          r = '{1'b1, best_index, 16'd0, 1'b0, 1'b0, 1'b0};
          pending_decodes.insert(pending_decodes.size(), r);
        end
      end
    end
    if (fin) begin
      err = overflow || elem_pos != 0;
      mean = (slot_cnt != 0) ? 16'(conf_sum / slot_cnt) : 16'd0;
      r = '{1'b0, 7'd0, mean, any_symbol && !err && mean >= shadow_cfg.accept_threshold,
            err, 1'b1};
      pending_decodes.insert(pending_decodes.size(), r);
      clear_tensor();
    end
  endtask

  task automatic send_beat(input logic [15:0] prob, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= prob;
    s_tlast <= fin;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    decode_element(prob, fin);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_write(addr, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [3:0] addr, input logic [31:0] want,
                          input logic [31:0] mask);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== want) report_mismatch($sformatf("read of %0h", addr),
                                                  prdata & mask, want);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic readback_config();
    apb_read(ADDR_VOCAB, 32'(shadow_cfg.vocab_size), 32'hFF);
    apb_read(ADDR_PAD, 32'(shadow_cfg.pad_index), 32'h7F);
    apb_read(ADDR_THR, 32'(shadow_cfg.accept_threshold), 32'hFFFF);
  endtask

  task automatic reconfigure(input int forced_vocab);
    logic [7:0]  vocab;
    logic [6:0]  pad;
    logic [15:0] thr;
    int          pick;
    pick = $urandom_range(99);
    if (forced_vocab >= 0) begin
      vocab = 8'(forced_vocab);
    end else if (pick < 4) begin
      case ($urandom_range(3))
        0: vocab = 8'd127;
        1: vocab = 8'd128;
        2: vocab = 8'd200;
        default: vocab = 8'd255;
      endcase
    end else if (pick < 12) begin
      vocab = 8'($urandom_range(1));
    end else if (pick < 30) begin
      vocab = 8'($urandom_range(40, 9));
    end else begin
      vocab = 8'($urandom_range(8, 2));
    end
    pick = $urandom_range(99);
    if (pick < 15) pad = 7'd0;
    else if (pick < 25) pad = 7'd127;
    else if (pick < 75) pad = 7'($urandom_range(effective_vocab(vocab) - 1));
    else pad = 7'($urandom_range(127));
    pick = $urandom_range(99);
    if (pick < 10) thr = 16'd0;
    else if (pick < 20) thr = 16'hFFFF;
    else if (pick < 60) thr = 16'($urandom_range(60000, 30000));
    else thr = 16'($urandom_range(65535));
    drain_results();
    apb_write(ADDR_VOCAB, 32'(vocab));
    apb_write(ADDR_PAD, 32'(pad));
    apb_write(ADDR_THR, 32'(thr));
    readback_config();
  endtask

  task automatic run_tensor();
    int unsigned v;
    int          slots;
    int          extra;
    int          winner;
    int          total;
    int          sent;
    int          mode;
    logic [15:0] peak;
    logic [15:0] prob;
    v = effective_vocab(shadow_cfg.vocab_size);
    if (v >= 64) begin
      slots = $urandom_range(1);
    end else if (v <= 2 && $urandom_range(99) < 25) begin
      slots = $urandom_range(sadt_pkg::MAX_SLOTS + 4, sadt_pkg::MAX_SLOTS - 1);
    end else begin
      slots = $urandom_range(6);
    end
    extra = (v > 1 && $urandom_range(99) < 15) ? $urandom_range(v - 1, 1) : 0;
    if (slots == 0 && extra == 0) slots = 1;
    total = slots * v + extra;
    sent = 0;
    for (int s = 0; s < slots; s++) begin
      if ($urandom_range(99) < 30 && shadow_cfg.pad_index < v) winner = shadow_cfg.pad_index;
      else winner = $urandom_range(v - 1);
      peak = 16'($urandom_range(65535, 20000));
      mode = $urandom_range(9);
      for (int e = 0; e < v; e++) begin
        if (e == winner) prob = peak;
        else if (mode < 6) prob = 16'($urandom_range(peak));
        else if (mode < 7) prob = peak;
        else prob = 16'($urandom());
        sent++;
        send_beat(prob, sent == total);
      end
    end
    for (int e = 0; e < extra; e++) begin
      sent++;
      send_beat(16'($urandom()), sent == total);
    end
  endtask

  task automatic check_decode();
    decode_t want;
    if (pending_decodes.size() == 0) begin
      report_mismatch("result beat with nothing pending", m_tdata, 32'd0);
    end else begin
      want = pending_decodes.pop_front();
      if (m_tuser !== want.is_symbol)
        report_mismatch("is_symbol", 32'(m_tuser), 32'(want.is_symbol));
      if (m_tdata[6:0] !== want.symbol_index)
        report_mismatch("symbol_index", 32'(m_tdata[6:0]), 32'(want.symbol_index));
      if (m_tdata[22:7] !== want.mean_confidence)
        report_mismatch("mean_confidence", 32'(m_tdata[22:7]), 32'(want.mean_confidence));
      if (m_tdata[23] !== want.accepted)
        report_mismatch("accepted", 32'(m_tdata[23]), 32'(want.accepted));
      if (m_tdata[24] !== want.size_error)
        report_mismatch("size_error", 32'(m_tdata[24]), 32'(want.size_error));
      if (m_tlast !== want.last_result)
        report_mismatch("last_result", 32'(m_tlast), 32'(want.last_result));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (m_tvalid && m_tready) check_decode();
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    shadow_cfg = '{sadt_pkg::VOCAB_RESET, sadt_pkg::PAD_RESET, sadt_pkg::THR_RESET};
    clear_tensor();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 33;
    recv_idle_pct = 57;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        drain_results();
        apb_write(directed_rows[i].addr, directed_rows[i].value);
        readback_config();
      end else begin
        send_beat(directed_rows[i].value[15:0], directed_rows[i].fin);
        if (directed_rows[i].typed) begin
          pending_decodes[pending_decodes.size() - 1] =
            '{1'b0, 7'd0, directed_rows[i].want_mean, directed_rows[i].want_acc,
              directed_rows[i].want_err, 1'b1};
        end
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 57;
          reconfigure(255);
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 33;
          reconfigure(128);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          reconfigure(1);
          hold_request = 1'b1;
        end
      endcase
      while (items_sent < PHASE_ITEMS * (phase + 1) + DIR_ROWS) begin
        run_tensor();
        if ($urandom_range(99) < 25) reconfigure(-1);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
